// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level of the I2C master engine.
// Depends on nothing; each macro takes the clock and the active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/i2cm_pkg.sv =====
// Shared types and constants of the I2C master transaction engine.
// Used by the front end, the bus engine and the top level.
package i2cm_pkg;

    localparam int DATA_BITS = 8;
    localparam int BIT_CNT_W = 4;
    localparam int TICK_W    = 3;

    // Raw request codes as they arrive on req_type
    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_START  = 2'd1;
    localparam logic [1:0] REQ_SUPPLY = 2'd2;

    // Classified request kinds
    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_START,
        CMD_SUPPLY,
        CMD_NONE
    } cmd_kind_t;

    // Bus phases
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START,
        PH_WBIT,
        PH_WTAIL,
        PH_TACK,
        PH_NEED,
        PH_WAIT,
        PH_RBIT,
        PH_ACK,
        PH_NACK,
        PH_STOP,
        PH_STOPERR
    } phase_t;

    // Classified request handed from front end to engine
    typedef struct packed {
        cmd_kind_t              kind;
        logic                   read_not_write;
        logic [DATA_BITS-1:0]   start_shift;
        logic [7:0]             start_count;
        logic [DATA_BITS-1:0]   write_byte;
        logic                   sda_level;
        logic                   scl_level;
    } cmd_t;

    // One result item
    typedef struct packed {
        logic                   scl_release;
        logic                   sda_release;
        logic                   busy_res;
        logic                   need_byte;
        logic [DATA_BITS-1:0]   read_byte;
        logic                   read_valid;
        logic                   read_last;
        logic                   done_res;
        logic                   nack_error;
    } res_t;

endpackage

// ===== rtl/i2cm_fifo.sv =====
// Small first-in first-out queue of WIDTH-bit entries.
// Self-contained; used for the request queue and the result queue.
module i2cm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    // Pointer and fill-level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/i2cm_front.sv =====
// Front end: decodes each request, precomputes start fields, queues it.
// Depends on i2cm_pkg and i2cm_fifo.
module i2cm_front #(
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    output logic         full,
    input  logic [1:0]   req_type,
    input  logic         read_not_write,
    input  logic [6:0]   device_address,
    input  logic [7:0]   byte_count,
    input  logic [7:0]   write_byte,
    input  logic         sda_level,
    input  logic         scl_level,
    output logic         cmd_valid,
    input  logic         cmd_pop,
    output i2cm_pkg::cmd_t cmd
);

    import i2cm_pkg::*;

    cmd_t cmd_in;
    logic cmd_empty;

    // Classify the request; a read of zero bytes runs as one byte
    always_comb
    begin
        case (req_type)
            REQ_TICK:   cmd_in.kind = CMD_TICK;
            REQ_START:  cmd_in.kind = CMD_START;
            REQ_SUPPLY: cmd_in.kind = CMD_SUPPLY;
            default:    cmd_in.kind = CMD_NONE;
        endcase
        cmd_in.read_not_write = read_not_write;
        cmd_in.start_shift    = {device_address, read_not_write};
        cmd_in.start_count    = (read_not_write && byte_count == 8'd0) ? 8'd1 : byte_count;
        cmd_in.write_byte     = write_byte;
        cmd_in.sda_level      = sda_level;
        cmd_in.scl_level      = scl_level;
    end

    i2cm_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (DEPTH)
    ) u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (cmd_in),
        .full      (full),
        .pop       (cmd_pop),
        .pop_data  (cmd),
        .empty     (cmd_empty)
    );

    assign cmd_valid = !cmd_empty;

endmodule

// ===== rtl/i2cm_engine.sv =====
// Back end: the bus phase machine; one queued request per step, one result each.
// Depends on i2cm_pkg.
module i2cm_engine (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  i2cm_pkg::cmd_t cmd,
    output logic           cmd_pop,
    output logic           res_push,
    output i2cm_pkg::res_t res,
    input  logic           res_full
);

    import i2cm_pkg::*;

    phase_t               phase_reg, phase_next;
    logic [TICK_W-1:0]    tick_reg, tick_next;
    logic [BIT_CNT_W-1:0] bit_reg, bit_next;
    logic [DATA_BITS-1:0] shift_reg, shift_next;
    logic [7:0]           bytes_reg, bytes_next;
    logic                 is_read_reg, is_read_next;
    logic                 scl_reg, scl_next;
    logic                 sda_reg, sda_next;

    logic                 step;
    logic [TICK_W-1:0]    t;
    logic [BIT_CNT_W-1:0] bc;
    logic [DATA_BITS-1:0] sh;
    logic [DATA_BITS-1:0] rb;
    logic                 rv, rl, done, err;

    assign step     = cmd_valid && !res_full;
    assign cmd_pop  = step;
    assign res_push = step;

    // Next state of the bus machine and the result of this step
    always_comb
    begin
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        bit_next     = bit_reg;
        shift_next   = shift_reg;
        bytes_next   = bytes_reg;
        is_read_next = is_read_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        rb           = '0;
        rv           = 1'b0;
        rl           = 1'b0;
        done         = 1'b0;
        err          = 1'b0;
        t            = tick_reg + 1'b1;
        bc           = bit_reg + 1'b1;
        sh           = shift_reg << 1;

        case (cmd.kind)
            CMD_START:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    is_read_next = cmd.read_not_write;
                    shift_next   = cmd.start_shift;
                    bytes_next   = cmd.start_count;
                    bit_next     = '0;
                    scl_next     = 1'b1;
                    sda_next     = 1'b1;
                    phase_next   = PH_START;
                    tick_next    = '0;
                end
            end
            CMD_SUPPLY:
            begin
                if (phase_reg == PH_NEED)
                begin
                    shift_next = cmd.write_byte;
                    bytes_next = bytes_reg - 8'd1;
                    bit_next   = '0;
                    sda_next   = cmd.write_byte[DATA_BITS-1];
                    phase_next = PH_WBIT;
                    tick_next  = '0;
                end
            end
            CMD_TICK:
            begin
                tick_next = t;
                case (phase_reg)
                    PH_START:
                    begin
                        if (t == 3'd1)      scl_next = 1'b1;
                        else if (t == 3'd2) sda_next = 1'b0;
                        else if (t == 3'd3) scl_next = 1'b0;
                        else
                        begin
                            bit_next   = '0;
                            sda_next   = shift_reg[DATA_BITS-1];
                            phase_next = PH_WBIT;
                            tick_next  = '0;
                        end
                    end
                    PH_WBIT:
                    begin
                        if (t == 3'd2)      scl_next = 1'b1;
                        else if (t == 3'd3) scl_next = 1'b0;
                        else if (t >= 3'd5)
                        begin
                            shift_next = sh;
                            bit_next   = bc;
                            tick_next  = '0;
                            if (bc >= BIT_CNT_W'(DATA_BITS))
                            begin
                                sda_next   = 1'b1;
                                phase_next = PH_WTAIL;
                            end
                            else
                            begin
                                sda_next = sh[DATA_BITS-1];
                            end
                        end
                    end
                    PH_WTAIL:
                    begin
                        phase_next = PH_TACK;
                        tick_next  = '0;
                    end
                    PH_TACK:
                    begin
                        if (t == 3'd1)      scl_next = 1'b1;
                        else if (t == 3'd2) shift_next = {{(DATA_BITS-1){1'b0}}, cmd.sda_level};
                        else if (t == 3'd3) scl_next = 1'b0;
                        else
                        begin
                            tick_next = '0;
                            if (shift_reg[0])
                            begin
                                scl_next   = 1'b0;
                                phase_next = PH_STOPERR;
                            end
                            else if (is_read_reg)
                            begin
                                scl_next   = 1'b1;
                                sda_next   = 1'b1;
                                phase_next = PH_WAIT;
                            end
                            else if (bytes_reg == 8'd0)
                            begin
                                scl_next   = 1'b0;
                                phase_next = PH_STOP;
                            end
                            else
                            begin
                                phase_next = PH_NEED;
                            end
                        end
                    end
                    PH_WAIT:
                    begin
                        tick_next = '0;
                        if (cmd.scl_level)
                        begin
                            bit_next   = '0;
                            shift_next = '0;
                            scl_next   = 1'b1;
                            sda_next   = 1'b1;
                            phase_next = PH_RBIT;
                        end
                    end
                    PH_RBIT:
                    begin
                        if (t == 3'd2)      shift_next = {shift_reg[DATA_BITS-2:0], cmd.sda_level};
                        else if (t == 3'd4) scl_next = 1'b0;
                        else if (t >= 3'd6)
                        begin
                            bit_next  = bc;
                            tick_next = '0;
                            if (bc >= BIT_CNT_W'(DATA_BITS))
                            begin
                                rb = shift_reg;
                                rv = 1'b1;
                                rl = (bytes_reg <= 8'd1);
                                if (bytes_reg <= 8'd1)
                                begin
                                    bytes_next = '0;
                                    sda_next   = 1'b1;
                                    phase_next = PH_NACK;
                                end
                                else
                                begin
                                    bytes_next = bytes_reg - 8'd1;
                                    sda_next   = 1'b0;
                                    phase_next = PH_ACK;
                                end
                            end
                            else
                            begin
                                scl_next = 1'b1;
                            end
                        end
                    end
                    PH_ACK:
                    begin
                        if (t == 3'd1)      scl_next = 1'b1;
                        else if (t == 3'd2) scl_next = 1'b0;
                        else
                        begin
                            bit_next   = '0;
                            shift_next = '0;
                            scl_next   = 1'b1;
                            sda_next   = 1'b1;
                            phase_next = PH_RBIT;
                            tick_next  = '0;
                        end
                    end
                    PH_NACK:
                    begin
                        if (t == 3'd1)      scl_next = 1'b1;
                        else if (t == 3'd2) scl_next = 1'b0;
                        else
                        begin
                            scl_next   = 1'b0;
                            phase_next = PH_STOP;
                            tick_next  = '0;
                        end
                    end
                    PH_STOP, PH_STOPERR:
                    begin
                        if (t == 3'd1)      sda_next = 1'b0;
                        else if (t == 3'd2) scl_next = 1'b1;
                        else if (t == 3'd3) sda_next = 1'b1;
                        else
                        begin
                            done       = 1'b1;
                            err        = (phase_reg == PH_STOPERR);
                            phase_next = PH_IDLE;
                            tick_next  = '0;
                        end
                    end
                    default:
                    begin
                        // idle or waiting for a byte: time does not accumulate
                        tick_next = '0;
                    end
                endcase
            end
            default:
            begin
                // unknown request: report the current drives only
            end
        endcase

        res.scl_release = scl_next;
        res.sda_release = sda_next;
        res.busy_res    = (phase_next != PH_IDLE);
        res.need_byte   = (phase_next == PH_NEED);
        res.read_byte   = rb;
        res.read_valid  = rv;
        res.read_last   = rl;
        res.done_res    = done;
        res.nack_error  = err;
    end

    // Bus machine state, updated once per executed request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            tick_reg    <= '0;
            bit_reg     <= '0;
            shift_reg   <= '0;
            bytes_reg   <= '0;
            is_read_reg <= 1'b0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            bit_reg     <= bit_next;
            shift_reg   <= shift_next;
            bytes_reg   <= bytes_next;
            is_read_reg <= is_read_next;
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
        end
    end

endmodule

// ===== rtl/i2c_master_transaction_engine_top.sv =====
// Top level of the I2C master transaction engine: front end, bus engine, result queue.
// Depends on i2cm_pkg, i2cm_fifo, i2cm_front, i2cm_engine and assert_macros.svh.
//
//   channel   | handshake        | fields
//   ----------+------------------+-----------------------------------------------
//   request   | push / full      | req_type read_not_write device_address
//             |                  | byte_count write_byte sda_level scl_level
//   result    | empty / pop      | scl_release sda_release busy_res need_byte
//             |                  | read_byte read_valid read_last done_res nack_error
//
// One request per clock sustained while results are popped as they arrive; each request yields exactly one result.
// A request's result reaches the result ports through both queues: the request queue holds it
// until the engine executes it, and the engine writes its result into the result queue.
// The engine steps only when the request queue holds an entry and the result queue
// has room, so a stalled pop fills the result queue before it backs up the requests.
// Reset (rst_n low, asynchronous) idles the bus with SCL and SDA released; queues empty.
`include "assert_macros.svh"

module i2c_master_transaction_engine_top #(
    parameter int FIFO_DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] req_type,
    input  logic       read_not_write,
    input  logic [6:0] device_address,
    input  logic [7:0] byte_count,
    input  logic [7:0] write_byte,
    input  logic       sda_level,
    input  logic       scl_level,
    output logic       empty,
    input  logic       pop,
    output logic       scl_release,
    output logic       sda_release,
    output logic       busy_res,
    output logic       need_byte,
    output logic [7:0] read_byte,
    output logic       read_valid,
    output logic       read_last,
    output logic       done_res,
    output logic       nack_error
);

    import i2cm_pkg::*;

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_pop;
    res_t eng_res;
    logic res_push;
    logic res_full;
    res_t out_res;

    // Request decode and queue
    i2cm_front #(
        .DEPTH (FIFO_DEPTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .req_type       (req_type),
        .read_not_write (read_not_write),
        .device_address (device_address),
        .byte_count     (byte_count),
        .write_byte     (write_byte),
        .sda_level      (sda_level),
        .scl_level      (scl_level),
        .cmd_valid      (cmd_valid),
        .cmd_pop        (cmd_pop),
        .cmd            (cmd)
    );

    // Bus phase machine
    i2cm_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_push  (res_push),
        .res       (eng_res),
        .res_full  (res_full)
    );

    // Result queue
    i2cm_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (FIFO_DEPTH)
    ) u_res_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (eng_res),
        .full      (res_full),
        .pop       (pop),
        .pop_data  (out_res),
        .empty     (empty)
    );

    assign scl_release = out_res.scl_release;
    assign sda_release = out_res.sda_release;
    assign busy_res    = out_res.busy_res;
    assign need_byte   = out_res.need_byte;
    assign read_byte   = out_res.read_byte;
    assign read_valid  = out_res.read_valid;
    assign read_last   = out_res.read_last;
    assign done_res    = out_res.done_res;
    assign nack_error  = out_res.nack_error;

    // Checks on the engine's results and the request path
    `ASSERT_IMPLY(a_err_with_done, clk, rst_n,
        res_push && eng_res.nack_error, eng_res.done_res,
        "nack_error without done_res")
    `ASSERT_IMPLY(a_done_bus_free, clk, rst_n,
        res_push && eng_res.done_res,
        !eng_res.busy_res && eng_res.scl_release && eng_res.sda_release,
        "STOP finished with bus not released")
    `ASSERT_IMPLY(a_read_in_txn, clk, rst_n,
        res_push && eng_res.read_valid, eng_res.busy_res && !eng_res.need_byte,
        "received byte outside a read")
    `ASSERT_NEXT(a_req_queued, clk, rst_n,
        push && !full, cmd_valid,
        "accepted request missing from queue")

endmodule
